// ===== src/qbvr_pkg.sv =====
// Shared types and widths for the quaternion body velocity rotator.
`timescale 1ns / 1ps

package qbvr_pkg;

	localparam int QUAT_WIDTH = 16;
	localparam int VEL_WIDTH  = 32;
	localparam int LANES      = 6;
	localparam int QP_W       = 2 * QUAT_WIDTH;
	localparam int MAT_W      = QP_W + 2;
	localparam int NORM_W     = QP_W + 1;
	localparam int PROD_W     = MAT_W + VEL_WIDTH;
	localparam int SUM_W      = PROD_W + 2;
	localparam int NUM_W      = SUM_W + 2;
	localparam int DIV_W      = NORM_W + 1;
	localparam int QUO_W      = VEL_WIDTH + 1;

	typedef logic signed [QUAT_WIDTH-1:0] quat_el_t;
	typedef logic signed [VEL_WIDTH-1:0]  vel_t;
	typedef logic signed [MAT_W-1:0]      mat_t;
	typedef logic [NORM_W-1:0]            norm_t;
	typedef logic [NUM_W-1:0]             num_t;
	typedef logic [DIV_W-1:0]             den_t;

	typedef struct packed {
		quat_el_t w;
		quat_el_t x;
		quat_el_t y;
		quat_el_t z;
	} quat_t;

	typedef struct packed {
		logic signed [QP_W-1:0] ww;
		logic signed [QP_W-1:0] xx;
		logic signed [QP_W-1:0] yy;
		logic signed [QP_W-1:0] zz;
		logic signed [QP_W-1:0] xy;
		logic signed [QP_W-1:0] wz;
		logic signed [QP_W-1:0] xz;
		logic signed [QP_W-1:0] wy;
		logic signed [QP_W-1:0] yz;
		logic signed [QP_W-1:0] wx;
	} qprod_t;

endpackage

// ===== src/qbvr_if.sv =====
// Channel interfaces: world-frame input and body-frame output.
`timescale 1ns / 1ps

interface qbvr_world_if;
	logic               valid;
	logic               ready;
	qbvr_pkg::quat_el_t quat_w;
	qbvr_pkg::quat_el_t quat_x;
	qbvr_pkg::quat_el_t quat_y;
	qbvr_pkg::quat_el_t quat_z;
	qbvr_pkg::vel_t     world_lin_x;
	qbvr_pkg::vel_t     world_lin_y;
	qbvr_pkg::vel_t     world_lin_z;
	qbvr_pkg::vel_t     world_ang_x;
	qbvr_pkg::vel_t     world_ang_y;
	qbvr_pkg::vel_t     world_ang_z;
	logic               frames_match;

	modport source (output valid, quat_w, quat_x, quat_y, quat_z, world_lin_x, world_lin_y,
		world_lin_z, world_ang_x, world_ang_y, world_ang_z, frames_match, input ready);
	modport sink (input valid, quat_w, quat_x, quat_y, quat_z, world_lin_x, world_lin_y,
		world_lin_z, world_ang_x, world_ang_y, world_ang_z, frames_match, output ready);
endinterface

interface qbvr_body_if;
	logic           valid;
	logic           ready;
	qbvr_pkg::vel_t body_lin_x;
	qbvr_pkg::vel_t body_lin_y;
	qbvr_pkg::vel_t body_lin_z;
	qbvr_pkg::vel_t body_ang_x;
	qbvr_pkg::vel_t body_ang_y;
	qbvr_pkg::vel_t body_ang_z;

	modport source (output valid, body_lin_x, body_lin_y, body_lin_z, body_ang_x, body_ang_y,
		body_ang_z, input ready);
	modport sink (input valid, body_lin_x, body_lin_y, body_lin_z, body_ang_x, body_ang_y,
		body_ang_z, output ready);
endinterface

// ===== src/qbvr_matrix.sv =====
// Rotation matrix and squared norm of the quaternion, two pipeline stages.
`timescale 1ns / 1ps

module qbvr_matrix (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic              vld,
	input  qbvr_pkg::quat_t   quat,
	input  qbvr_pkg::vel_t    vel [qbvr_pkg::LANES],
	output logic              mat_vld,
	output qbvr_pkg::mat_t    m [3][3],
	output qbvr_pkg::norm_t   n,
	output qbvr_pkg::vel_t    vel_out [qbvr_pkg::LANES]
);

	localparam int MW = qbvr_pkg::MAT_W;
	localparam int NW = qbvr_pkg::NORM_W;
	localparam int L  = qbvr_pkg::LANES;

	logic             vld_s1;
	qbvr_pkg::qprod_t qp_s1;
	qbvr_pkg::vel_t   vel_s1 [L];

	logic             vld_s2;
	qbvr_pkg::mat_t   m_s2 [3][3];
	qbvr_pkg::norm_t  n_s2;
	qbvr_pkg::vel_t   vel_s2 [L];

	qbvr_pkg::mat_t   ww, xx, yy, zz;
	qbvr_pkg::mat_t   d01, d10, d02, d20, d12, d21;
	qbvr_pkg::norm_t  n_c;
	qbvr_pkg::mat_t   m_c [3][3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= vld;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			qp_s1.ww <= quat.w * quat.w;
			qp_s1.xx <= quat.x * quat.x;
			qp_s1.yy <= quat.y * quat.y;
			qp_s1.zz <= quat.z * quat.z;
			qp_s1.xy <= quat.x * quat.y;
			qp_s1.wz <= quat.w * quat.z;
			qp_s1.xz <= quat.x * quat.z;
			qp_s1.wy <= quat.w * quat.y;
			qp_s1.yz <= quat.y * quat.z;
			qp_s1.wx <= quat.w * quat.x;
			vel_s1   <= vel;
		end
	end

	always_comb begin
		ww  = MW'(qp_s1.ww);
		xx  = MW'(qp_s1.xx);
		yy  = MW'(qp_s1.yy);
		zz  = MW'(qp_s1.zz);
		d01 = MW'(qp_s1.xy) - MW'(qp_s1.wz);
		d10 = MW'(qp_s1.xy) + MW'(qp_s1.wz);
		d02 = MW'(qp_s1.xz) + MW'(qp_s1.wy);
		d20 = MW'(qp_s1.xz) - MW'(qp_s1.wy);
		d12 = MW'(qp_s1.yz) - MW'(qp_s1.wx);
		d21 = MW'(qp_s1.yz) + MW'(qp_s1.wx);
		n_c = NW'($unsigned(qp_s1.ww)) + NW'($unsigned(qp_s1.xx))
			+ NW'($unsigned(qp_s1.yy)) + NW'($unsigned(qp_s1.zz));
		m_c[0][0] = ww + xx - yy - zz;
		m_c[1][1] = ww - xx + yy - zz;
		m_c[2][2] = ww - xx - yy + zz;
		m_c[0][1] = {d01[MW-2:0], 1'b0};
		m_c[1][0] = {d10[MW-2:0], 1'b0};
		m_c[0][2] = {d02[MW-2:0], 1'b0};
		m_c[2][0] = {d20[MW-2:0], 1'b0};
		m_c[1][2] = {d12[MW-2:0], 1'b0};
		m_c[2][1] = {d21[MW-2:0], 1'b0};
		// zero quaternion: identity over a unit norm passes the velocities through
		if (n_c == '0) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					m_c[i][j] = (i == j) ? MW'(1) : '0;
				end
			end
			n_c = NW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_s2   <= m_c;
			n_s2   <= n_c;
			vel_s2 <= vel_s1;
		end
	end

	assign mat_vld = vld_s2;
	assign m       = m_s2;
	assign n       = n_s2;
	assign vel_out = vel_s2;

endmodule

// ===== src/qbvr_rotate.sv =====
// Matrix-vector products and rounding numerators, two pipeline stages.
`timescale 1ns / 1ps

module qbvr_rotate (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  logic             vld,
	input  qbvr_pkg::mat_t   m [3][3],
	input  qbvr_pkg::norm_t  n,
	input  qbvr_pkg::vel_t   vel [qbvr_pkg::LANES],
	output logic             num_vld,
	output qbvr_pkg::num_t   num [qbvr_pkg::LANES],
	output logic             neg [qbvr_pkg::LANES],
	output qbvr_pkg::den_t   den
);

	localparam int L  = qbvr_pkg::LANES;
	localparam int PW = qbvr_pkg::PROD_W;
	localparam int SW = qbvr_pkg::SUM_W;
	localparam int NW = qbvr_pkg::NUM_W;
	localparam int DW = qbvr_pkg::DIV_W;

	logic                 vld_s3;
	logic signed [PW-1:0] prod_s3 [L][3];
	qbvr_pkg::norm_t      n_s3;

	logic                 vld_s4;
	qbvr_pkg::num_t       num_s4 [L];
	logic                 neg_s4 [L];
	qbvr_pkg::den_t       den_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s3 <= vld;
			vld_s4 <= vld_s3;
		end
	end

	// lane k: column k mod 3 of the matrix against the linear or angular vector
	for (genvar k = 0; k < L; k++) begin : g_lane
		for (genvar j = 0; j < 3; j++) begin : g_term
			always_ff @(posedge clk) begin
				if (adv) begin
					prod_s3[k][j] <= m[j][k % 3] * vel[(k / 3) * 3 + j];
				end
			end
		end

		logic signed [SW-1:0] sum;
		logic [SW-1:0]        mag;
		always_comb begin
			sum = SW'(prod_s3[k][0]) + SW'(prod_s3[k][1]) + SW'(prod_s3[k][2]);
			mag = sum[SW-1] ? SW'($unsigned(-sum)) : SW'($unsigned(sum));
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				num_s4[k] <= NW'({mag, 1'b0}) + NW'(n_s3);
				neg_s4[k] <= sum[SW-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			n_s3   <= n;
			den_s4 <= {n_s3, 1'b0};
		end
	end

	assign num_vld = vld_s4;
	assign num     = num_s4;
	assign neg     = neg_s4;
	assign den     = den_s4;

	initial_den_width_check: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s4 |-> den_s4[0] == 1'b0 && den_s4 != DW'(0))
		else $error("divisor not twice a nonzero norm");

endmodule

// ===== src/qbvr_divider.sv =====
// Pipelined restoring divider, one quotient bit per stage, with saturation.
`timescale 1ns / 1ps

module qbvr_divider (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  logic             vld,
	input  qbvr_pkg::num_t   num [qbvr_pkg::LANES],
	input  logic             neg [qbvr_pkg::LANES],
	input  qbvr_pkg::den_t   den,
	output logic             res_vld,
	output qbvr_pkg::vel_t   res [qbvr_pkg::LANES]
);

	localparam int L  = qbvr_pkg::LANES;
	localparam int QW = qbvr_pkg::QUO_W;
	localparam int DW = qbvr_pkg::DIV_W;
	localparam int NW = qbvr_pkg::NUM_W;
	localparam int VW = qbvr_pkg::VEL_WIDTH;
	localparam int HW = NW - QW;

	localparam logic [QW-1:0] Q_POS_MAX = {2'b00, {(VW - 1){1'b1}}};
	localparam logic [QW-1:0] Q_NEG_MAX = {2'b01, {(VW - 1){1'b0}}};
	localparam logic [VW-1:0] VEL_MAX   = {1'b0, {(VW - 1){1'b1}}};
	localparam logic [VW-1:0] VEL_MIN   = {1'b1, {(VW - 1){1'b0}}};

	logic            vld_s [QW+1];
	logic [DW-1:0]   den_s [QW+1];
	logic [DW-1:0]   rem_s [QW+1][L];
	logic [QW-1:0]   word_s [QW+1][L];
	logic            neg_s [QW+1][L];
	logic            ovf_s [QW+1][L];

	logic            res_vld_q;
	qbvr_pkg::vel_t  res_q [L];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= QW; k++) begin
				vld_s[k] <= 1'b0;
			end
			res_vld_q <= 1'b0;
		end else if (adv) begin
			vld_s[0] <= vld;
			for (int k = 0; k < QW; k++) begin
				vld_s[k+1] <= vld_s[k];
			end
			res_vld_q <= vld_s[QW];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			den_s[0] <= den;
			for (int k = 0; k < QW; k++) begin
				den_s[k+1] <= den_s[k];
			end
		end
	end

	for (genvar l = 0; l < L; l++) begin : g_lane
		logic [HW-1:0] head;
		logic          ovf;
		logic [VW-1:0] sat;

		// a quotient that needs more than QW bits saturates anyway
		always_comb begin
			head = num[l][NW-1:QW];
			ovf  = head >= HW'(den);
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				ovf_s[0][l]  <= ovf;
				neg_s[0][l]  <= neg[l];
				rem_s[0][l]  <= ovf ? '0 : head[DW-1:0];
				word_s[0][l] <= num[l][QW-1:0];
			end
		end

		for (genvar k = 0; k < QW; k++) begin : g_step
			logic [DW:0] trial;
			logic        ge;
			always_comb begin
				trial = {rem_s[k][l], word_s[k][l][QW-1]};
				ge    = trial >= {1'b0, den_s[k]};
			end

			always_ff @(posedge clk) begin
				if (adv) begin
					rem_s[k+1][l]  <= ge ? DW'(trial - {1'b0, den_s[k]}) : trial[DW-1:0];
					word_s[k+1][l] <= {word_s[k][l][QW-2:0], ge};
					neg_s[k+1][l]  <= neg_s[k][l];
					ovf_s[k+1][l]  <= ovf_s[k][l];
				end
			end
		end

		always_comb begin
			if (neg_s[QW][l]) begin
				sat = (ovf_s[QW][l] || word_s[QW][l] > Q_NEG_MAX) ? VEL_MIN
					: VW'(QW'(0) - word_s[QW][l]);
			end else begin
				sat = (ovf_s[QW][l] || word_s[QW][l] > Q_POS_MAX) ? VEL_MAX
					: word_s[QW][l][VW-1:0];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				res_q[l] <= sat;
			end
		end
	end

	assign res_vld = res_vld_q;
	assign res     = res_q;

	rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[QW] |-> rem_s[QW][0] < den_s[QW] && rem_s[QW][L-1] < den_s[QW])
		else $error("divider remainder not below divisor");

	den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[0] |-> den_s[0] != '0)
		else $error("divider entered with zero divisor");

	stall_holds_chain: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(vld_s[QW]) && $stable(res_vld_q) && $stable(vld_s[0]))
		else $error("pipeline moved during stall");

endmodule

// ===== src/quaternion_body_velocity_rotate_top.sv =====
// Top level: rotates world-frame velocities into the body frame of a quaternion.
//
//  channel  | direction | handshake     | payload
//  ---------+-----------+---------------+------------------------------------------
//  world    | sink      | valid/ready   | quat_w..z, world_lin_*, world_ang_*, match
//  body     | source    | valid/ready   | body_lin_*, body_ang_*
//
// One transaction is taken every cycle while body does not stall; a result passes through
// the matrix and product stages, the divider input register, the 33-stage bit-per-stage
// divider and the output stage.
// Transactions with frames_match clear enter as bubbles and produce no result.
// Reset clears only the valid bits; data registers are not reset.
// A stall on body freezes the whole pipeline and drops ready on world.
`timescale 1ns / 1ps

module quaternion_body_velocity_rotate_top (
	input  logic       clk,
	input  logic       arst_n,
	qbvr_world_if.sink world,
	qbvr_body_if.source body
);

	localparam int L = qbvr_pkg::LANES;

	logic            adv;
	qbvr_pkg::quat_t quat;
	qbvr_pkg::vel_t  vel [L];

	logic            mat_vld;
	qbvr_pkg::mat_t  m [3][3];
	qbvr_pkg::norm_t n;
	qbvr_pkg::vel_t  mat_vel [L];

	logic            num_vld;
	qbvr_pkg::num_t  num [L];
	logic            neg [L];
	qbvr_pkg::den_t  den;

	logic            res_vld;
	qbvr_pkg::vel_t  res [L];

	// advance whenever the output register is free or being drained
	assign adv         = !res_vld || body.ready;
	assign world.ready = adv;

	always_comb begin
		quat.w = world.quat_w;
		quat.x = world.quat_x;
		quat.y = world.quat_y;
		quat.z = world.quat_z;
		vel[0] = world.world_lin_x;
		vel[1] = world.world_lin_y;
		vel[2] = world.world_lin_z;
		vel[3] = world.world_ang_x;
		vel[4] = world.world_ang_y;
		vel[5] = world.world_ang_z;
	end

	qbvr_matrix u_matrix (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.vld     (world.valid && world.frames_match),
		.quat    (quat),
		.vel     (vel),
		.mat_vld (mat_vld),
		.m       (m),
		.n       (n),
		.vel_out (mat_vel)
	);

	qbvr_rotate u_rotate (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.vld     (mat_vld),
		.m       (m),
		.n       (n),
		.vel     (mat_vel),
		.num_vld (num_vld),
		.num     (num),
		.neg     (neg),
		.den     (den)
	);

	qbvr_divider u_divider (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.vld     (num_vld),
		.num     (num),
		.neg     (neg),
		.den     (den),
		.res_vld (res_vld),
		.res     (res)
	);

	assign body.valid      = res_vld;
	assign body.body_lin_x = res[0];
	assign body.body_lin_y = res[1];
	assign body.body_lin_z = res[2];
	assign body.body_ang_x = res[3];
	assign body.body_ang_y = res[4];
	assign body.body_ang_z = res[5];

	dropped_item_no_entry: assert property (@(posedge clk) disable iff (!arst_n)
		adv && !(world.valid && world.frames_match) ##1 adv |=> !mat_vld)
		else $error("dropped transaction entered the pipeline");

	ready_tracks_output: assert property (@(posedge clk) disable iff (!arst_n)
		res_vld && !body.ready |=> res_vld && !$past(world.ready))
		else $error("pipeline advanced with output held");

	held_result_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(num_vld) && $stable(mat_vld))
		else $error("inner stages moved during stall");

endmodule
